[rtl/bufc_pkg.sv]
// Shared types and constants for the byte unstuffing frame checker.
package bufc_pkg;

    localparam int MAX_FRAME_BYTES_DEFAULT = 256;
    localparam int QUEUE_DEPTH             = 4;
    localparam int QUEUE_PTR_W             = $clog2(QUEUE_DEPTH);
    localparam int CFG_ADDR_W              = 5;
    localparam int CFG_DATA_W              = 32;
    localparam int FRAME_LEN_W             = 9;

    localparam logic [2:0] REG_ESCAPE_CODE            = 3'd0;
    localparam logic [2:0] REG_DELIMITER_VALUE        = 3'd1;
    localparam logic [2:0] REG_ESCAPED_DELIMITER_CODE = 3'd2;
    localparam logic [2:0] REG_ESCAPED_ESCAPE_CODE    = 3'd3;
    localparam logic [2:0] REG_FRAME_LENGTH           = 3'd4;

    localparam logic [7:0] RESET_ESCAPE_CODE            = 8'd125;
    localparam logic [7:0] RESET_DELIMITER_VALUE        = 8'd126;
    localparam logic [7:0] RESET_ESCAPED_DELIMITER_CODE = 8'd94;
    localparam logic [7:0] RESET_ESCAPED_ESCAPE_CODE    = 8'd93;
    localparam logic [FRAME_LEN_W-1:0] RESET_FRAME_LENGTH = 9'd32;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_ESCAPE = 2'd1,
        STATUS_BAD_LENGTH = 2'd2,
        STATUS_BAD_XOR    = 2'd3
    } frame_status_t;

    typedef struct packed {
        logic [7:0]             escape_code;
        logic [7:0]             delimiter_value;
        logic [7:0]             escaped_delimiter_code;
        logic [7:0]             escaped_escape_code;
        logic [FRAME_LEN_W-1:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       final_byte;
        logic       is_escape;
        logic       is_esc_delim;
        logic       is_esc_escape;
    } entry_t;

endpackage

[rtl/bufc_cfg.sv]
// Configuration register file behind the APB-style port.
module bufc_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bufc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bufc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bufc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output bufc_pkg::cfg_t                     cfg
);

    bufc_pkg::cfg_t cfg_reg;
    bufc_pkg::cfg_t cfg_next;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign reg_index = paddr[bufc_pkg::CFG_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                bufc_pkg::REG_ESCAPE_CODE:
                    cfg_next.escape_code = pwdata[7:0];
                bufc_pkg::REG_DELIMITER_VALUE:
                    cfg_next.delimiter_value = pwdata[7:0];
                bufc_pkg::REG_ESCAPED_DELIMITER_CODE:
                    cfg_next.escaped_delimiter_code = pwdata[7:0];
                bufc_pkg::REG_ESCAPED_ESCAPE_CODE:
                    cfg_next.escaped_escape_code = pwdata[7:0];
                bufc_pkg::REG_FRAME_LENGTH:
                    cfg_next.frame_length = pwdata[bufc_pkg::FRAME_LEN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            bufc_pkg::REG_ESCAPE_CODE:
                prdata = {24'd0, cfg_reg.escape_code};
            bufc_pkg::REG_DELIMITER_VALUE:
                prdata = {24'd0, cfg_reg.delimiter_value};
            bufc_pkg::REG_ESCAPED_DELIMITER_CODE:
                prdata = {24'd0, cfg_reg.escaped_delimiter_code};
            bufc_pkg::REG_ESCAPED_ESCAPE_CODE:
                prdata = {24'd0, cfg_reg.escaped_escape_code};
            bufc_pkg::REG_FRAME_LENGTH:
                prdata = {23'd0, cfg_reg.frame_length};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.escape_code            <= bufc_pkg::RESET_ESCAPE_CODE;
            cfg_reg.delimiter_value        <= bufc_pkg::RESET_DELIMITER_VALUE;
            cfg_reg.escaped_delimiter_code <= bufc_pkg::RESET_ESCAPED_DELIMITER_CODE;
            cfg_reg.escaped_escape_code    <= bufc_pkg::RESET_ESCAPED_ESCAPE_CODE;
            cfg_reg.frame_length           <= bufc_pkg::RESET_FRAME_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/bufc_front.sv]
// Front end: classifies each incoming raw byte against the escape codes.
module bufc_front
(
    input  logic               [7:0] raw_byte,
    input  logic                     final_byte,
    input  bufc_pkg::cfg_t           cfg,
    output bufc_pkg::entry_t         entry
);

    // The comparisons are done here so that the decode stage only sees flags.
    always_comb
    begin
        entry.raw_byte      = raw_byte;
        entry.final_byte    = final_byte;
        entry.is_escape     = (raw_byte == cfg.escape_code);
        entry.is_esc_delim  = (raw_byte == cfg.escaped_delimiter_code);
        entry.is_esc_escape = (raw_byte == cfg.escaped_escape_code);
    end

endmodule

[rtl/bufc_queue.sv]
// Short FIFO between the classifying front end and the decode stage.
module bufc_queue
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  bufc_pkg::entry_t         push_data,
    input  logic                     pop,
    output bufc_pkg::entry_t         pop_data,
    output logic                     full,
    output logic                     empty
);

    localparam int CNT_W = $clog2(bufc_pkg::QUEUE_DEPTH + 1);

    bufc_pkg::entry_t                   slot_reg [bufc_pkg::QUEUE_DEPTH];
    logic [bufc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [bufc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [bufc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [bufc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full     = (count_reg == CNT_W'(bufc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/bufc_back.sv]
// Decode stage: frame state, unescaping, checksum and the output register.
module bufc_back
#(
    parameter int MAX_FRAME_BYTES = bufc_pkg::MAX_FRAME_BYTES_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bufc_pkg::cfg_t           cfg,
    input  logic                     q_empty,
    input  bufc_pkg::entry_t         q_data,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     byte_valid,
    output logic               [7:0] decoded_byte,
    output logic               [7:0] byte_position,
    output logic                     frame_end,
    output logic               [1:0] frame_status
);

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (LEN_W > bufc_pkg::FRAME_LEN_W) ? LEN_W : bufc_pkg::FRAME_LEN_W;

    logic                 esc_pending_reg;
    logic                 esc_pending_next;
    logic                 bad_seen_reg;
    logic                 bad_seen_next;
    logic [LEN_W-1:0]     count_reg;
    logic [LEN_W-1:0]     count_next;
    logic [7:0]           xor_reg;
    logic [7:0]           xor_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 byte_valid_reg;
    logic [7:0]           decoded_byte_reg;
    logic [7:0]           byte_position_reg;
    logic                 frame_end_reg;
    bufc_pkg::frame_status_t status_reg;

    logic [CMP_W-1:0]     len_wide;
    logic [CMP_W-1:0]     limit_wide;
    logic [LEN_W-1:0]     limit;
    logic                 active;
    logic                 have;
    logic [7:0]           data;
    bufc_pkg::frame_status_t status;

    // Out-of-range lengths are clamped into one to MAX_FRAME_BYTES.
    always_comb
    begin
        len_wide = CMP_W'(cfg.frame_length);
        priority if (len_wide == '0)
        begin
            limit_wide = CMP_W'(1);
        end
        else if (len_wide > CMP_W'(MAX_FRAME_BYTES))
        begin
            limit_wide = CMP_W'(MAX_FRAME_BYTES);
        end
        else
        begin
            limit_wide = len_wide;
        end
        limit = LEN_W'(limit_wide);
    end

    assign q_pop = !q_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        esc_pending_next = esc_pending_reg;
        bad_seen_next    = bad_seen_reg;
        count_next       = count_reg;
        xor_next         = xor_reg;
        have             = 1'b0;
        data             = q_data.raw_byte;
        status           = bufc_pkg::STATUS_OK;
        active           = !bad_seen_reg && (count_reg < limit);

        if (active)
        begin
            priority if (esc_pending_reg)
            begin
                esc_pending_next = 1'b0;
                priority if (q_data.is_esc_delim)
                begin
                    data = cfg.delimiter_value;
                    have = 1'b1;
                end
                else if (q_data.is_esc_escape)
                begin
                    data = cfg.escape_code;
                    have = 1'b1;
                end
                else
                begin
                    bad_seen_next = 1'b1;
                end
            end
            else if (q_data.is_escape)
            begin
                // An escape on the last byte has no follower.
                if (q_data.final_byte)
                begin
                    bad_seen_next = 1'b1;
                end
                else
                begin
                    esc_pending_next = 1'b1;
                end
            end
            else
            begin
                have = 1'b1;
            end
        end

        if (have)
        begin
            count_next = count_reg + 1'b1;
            xor_next   = xor_reg ^ data;
        end

        if (q_data.final_byte)
        begin
            priority if (bad_seen_next)
            begin
                status = bufc_pkg::STATUS_BAD_ESCAPE;
            end
            else if (count_next != limit)
            begin
                status = bufc_pkg::STATUS_BAD_LENGTH;
            end
            else if (xor_next != 8'd0)
            begin
                status = bufc_pkg::STATUS_BAD_XOR;
            end
            else
            begin
                status = bufc_pkg::STATUS_OK;
            end
            esc_pending_next = 1'b0;
            bad_seen_next    = 1'b0;
            count_next       = '0;
            xor_next         = 8'd0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = have || q_data.final_byte;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pending_reg <= 1'b0;
            bad_seen_reg    <= 1'b0;
            count_reg       <= '0;
            xor_reg         <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                esc_pending_reg <= esc_pending_next;
                bad_seen_reg    <= bad_seen_next;
                count_reg       <= count_next;
                xor_reg         <= xor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            byte_valid_reg    <= have;
            decoded_byte_reg  <= have ? data : 8'd0;
            byte_position_reg <= have ? 8'(count_reg) : 8'd0;
            frame_end_reg     <= q_data.final_byte;
            status_reg        <= status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_valid    = byte_valid_reg;
    assign decoded_byte  = decoded_byte_reg;
    assign byte_position = byte_position_reg;
    assign frame_end     = frame_end_reg;
    assign frame_status  = status_reg;

endmodule

[rtl/byte_unstuff_frame_checker_top.sv]
// Top level of the byte unstuffing frame checker with XOR checksum.
// A taken request passes through the queue and then into the output register, and waits
// longer while the queue holds older requests or the output is stalled.
// Throughput: one raw byte per cycle while the output is not stalled, set by the back end.
// Reset: rst_n clears frame state, queue and output valid at once and loads the register
// defaults; no clearing pass is needed, so requests are taken right after reset.
module byte_unstuff_frame_checker_top
#(
    parameter int MAX_FRAME_BYTES = bufc_pkg::MAX_FRAME_BYTES_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Raw byte request channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                         [7:0] raw_byte,
    input  logic                               final_byte,

    // Decoded result request channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               byte_valid,
    output logic                         [7:0] decoded_byte,
    output logic                         [7:0] byte_position,
    output logic                               frame_end,
    output logic                         [1:0] frame_status,

    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bufc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bufc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bufc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    bufc_pkg::cfg_t   cfg;
    bufc_pkg::entry_t front_entry;
    bufc_pkg::entry_t q_data;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    // Register file. Writes must happen only while the datapath is idle; the block does not
    // enforce this, and the decoded values feed the front and back ends directly.
    bufc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The front end tags each byte as escape, escaped delimiter or escaped
    // escape so the back end does no byte compares of its own.
    bufc_front u_front
    (
        .raw_byte   (raw_byte),
        .final_byte (final_byte),
        .cfg        (cfg),
        .entry      (front_entry)
    );

    // A request is taken whenever the queue has room; stall is the full flag
    // alone, so input flow does not wait on the output side directly.
    assign in_stall = q_full;

    bufc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_entry),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end pops one entry per cycle whenever its output register is
    // empty or being drained. Bytes that yield no result still pop, but leave
    // the output register empty.
    bufc_back
    #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_valid    (byte_valid),
        .decoded_byte  (decoded_byte),
        .byte_position (byte_position),
        .frame_end     (frame_end),
        .frame_status  (frame_status)
    );

endmodule

[sim/tb.sv]
// Self-checking testbench for the byte unstuffing frame checker top level.
module tb;
    import bufc_pkg::*;

    localparam int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT;
    localparam int RESET_CYCLES    = 7;
    // A result leaves the block once its request has passed the queue and the output register;
    // requests that cause no result may still sit in the queue, so allow the queue depth several times.
    localparam int SETTLE_CYCLES   = 2 * QUEUE_DEPTH + 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_COUNT     = 8;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic          byte_valid;
        logic [7:0]    decoded_byte;
        logic [7:0]    byte_position;
        logic          frame_end;
        frame_status_t frame_status;
    } decode_result_t;

    typedef enum bit {ROW_ITEM, ROW_LENGTH} row_kind_t;

    typedef struct {
        row_kind_t      kind;
        logic [8:0]     new_length;
        logic [7:0]     raw;
        logic           last;
        bit             typed;
        bit             typed_has;
        decode_result_t typed_result;
    } stimulus_row_t;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef enum {SHAPE_GOOD, SHAPE_BAD_SUM, SHAPE_ODD_LENGTH, SHAPE_BAD_ESCAPE, SHAPE_NOISE}
        frame_shape_t;

    localparam decode_result_t NO_RESULT = '0;
    localparam int DIRECTED_ROWS = 24;

    // Directed part. Rows 0 to 14 run with the register defaults (escape 7D, delimiter 7E,
    // escaped delimiter 5E, escaped escape 5D, length 32); the rest run with a length of one.
    stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, 8'h00, 8'd0, 1'b0, STATUS_OK}},
        '{ROW_ITEM,   9'd0, 8'hFF, 1'b0, 1'b1, 1'b1, '{1'b1, 8'hFF, 8'd1, 1'b0, STATUS_OK}},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h5E, 1'b0, 1'b1, 1'b1, '{1'b1, 8'h7E, 8'd2, 1'b0, STATUS_OK}},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h5D, 1'b0, 1'b1, 1'b1, '{1'b1, 8'h7D, 8'd3, 1'b0, STATUS_OK}},
        '{ROW_ITEM,   9'd0, 8'h3C, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h11, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h22, 1'b1, 1'b1, 1'b1,
          '{1'b0, 8'h00, 8'd0, 1'b1, STATUS_BAD_ESCAPE}},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b1, 1'b1, 1'b1,
          '{1'b0, 8'h00, 8'd0, 1'b1, STATUS_BAD_ESCAPE}},
        '{ROW_ITEM,   9'd0, 8'hA5, 1'b1, 1'b1, 1'b1,
          '{1'b1, 8'hA5, 8'd0, 1'b1, STATUS_BAD_LENGTH}},
        '{ROW_ITEM,   9'd0, 8'h5A, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h7E, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_LENGTH, 9'd1, 8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h00, 1'b1, 1'b1, 1'b1, '{1'b1, 8'h00, 8'd0, 1'b1, STATUS_OK}},
        '{ROW_ITEM,   9'd0, 8'h80, 1'b1, 1'b1, 1'b1,
          '{1'b1, 8'h80, 8'd0, 1'b1, STATUS_BAD_XOR}},
        '{ROW_ITEM,   9'd0, 8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, 8'h00, 8'd0, 1'b0, STATUS_OK}},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h44, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b1, 1'b1, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b1, STATUS_OK}},
        '{ROW_ITEM,   9'd0, 8'h7D, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{ROW_ITEM,   9'd0, 8'h5D, 1'b1, 1'b1, 1'b1,
          '{1'b1, 8'h7D, 8'd0, 1'b1, STATUS_BAD_XOR}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            raw_byte = 8'h00;
    logic                  final_byte = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  byte_valid;
    logic [7:0]            decoded_byte;
    logic [7:0]            byte_position;
    logic                  frame_end;
    logic [1:0]            frame_status;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the registers and of the frame state kept by the decoder.
    cfg_t       shadow_cfg = '{RESET_ESCAPE_CODE, RESET_DELIMITER_VALUE,
                               RESET_ESCAPED_DELIMITER_CODE, RESET_ESCAPED_ESCAPE_CODE,
                               RESET_FRAME_LENGTH};
    logic       escape_pending = 1'b0;
    logic [8:0] decoded_count = '0;
    logic [7:0] running_xor = '0;
    logic       bad_escape_seen = 1'b0;

    decode_result_t decodes_due [$];
    int             mismatch_count = 0;
    int             items_sent = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             stall_pct = 0;

    byte_unstuff_frame_checker_top #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_byte     (raw_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_valid   (byte_valid),
        .decoded_byte (decoded_byte),
        .byte_position(byte_position),
        .frame_end    (frame_end),
        .frame_status (frame_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Length limit actually applied: zero counts as one, oversize values clamp to the maximum.
    function automatic int frame_limit();
        int n;
        n = int'(shadow_cfg.frame_length);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_FRAME_BYTES)
        begin
            n = MAX_FRAME_BYTES;
        end
        return n;
    endfunction

    // Decodes one raw byte against the shadow state. Returns 1 when the byte causes a result.
    function automatic bit unstuff_byte(input logic [7:0] raw, input logic last,
                                        output decode_result_t res);
        int         limit;
        bit         have;
        logic [7:0] data;
        limit = frame_limit();
        have  = 1'b0;
        data  = 8'h00;
        res   = '0;
        // Nothing is decoded once an escape went bad or the frame is full.
        if (!bad_escape_seen && int'(decoded_count) < limit)
        begin
            if (escape_pending)
            begin
                escape_pending = 1'b0;
                if (raw == shadow_cfg.escaped_delimiter_code)
                begin
                    data = shadow_cfg.delimiter_value;
                    have = 1'b1;
                end
                else if (raw == shadow_cfg.escaped_escape_code)
                begin
                    data = shadow_cfg.escape_code;
                    have = 1'b1;
                end
                else
                begin
                    bad_escape_seen = 1'b1;
                end
            end
            else if (raw == shadow_cfg.escape_code)
            begin
                // An escape with no follower inside the frame is an error at once.
                if (last)
                begin
                    bad_escape_seen = 1'b1;
                end
                else
                begin
                    escape_pending = 1'b1;
                end
            end
            else
            begin
                data = raw;
                have = 1'b1;
            end
        end
        if (have)
        begin
            res.byte_valid    = 1'b1;
            res.decoded_byte  = data;
            res.byte_position = decoded_count[7:0];
            running_xor       = running_xor ^ data;
            decoded_count     = decoded_count + 9'd1;
        end
        if (last)
        begin
            res.frame_end = 1'b1;
            if (bad_escape_seen)
            begin
                res.frame_status = STATUS_BAD_ESCAPE;
            end
            else if (int'(decoded_count) != limit)
            begin
                res.frame_status = STATUS_BAD_LENGTH;
            end
            else if (running_xor != 8'h00)
            begin
                res.frame_status = STATUS_BAD_XOR;
            end
            else
            begin
                res.frame_status = STATUS_OK;
            end
            escape_pending  = 1'b0;
            decoded_count   = '0;
            running_xor     = '0;
            bad_escape_seen = 1'b0;
        end
        return have || last;
    endfunction

    task automatic report_mismatch(input string what, input decode_result_t want,
                                   input decode_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $write("%s: expected valid=%0d byte=%02h pos=%0d end=%0d status=%0d, ",
                   what, want.byte_valid, want.decoded_byte, want.byte_position,
                   want.frame_end, want.frame_status);
            $display("got valid=%0d byte=%02h pos=%0d end=%0d status=%0d",
                     got.byte_valid, got.decoded_byte, got.byte_position,
                     got.frame_end, got.frame_status);
        end
    endtask

    // One APB write: setup cycle, then access cycle until pready is seen.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ESCAPE_CODE:            shadow_cfg.escape_code            = value[7:0];
            REG_DELIMITER_VALUE:        shadow_cfg.delimiter_value        = value[7:0];
            REG_ESCAPED_DELIMITER_CODE: shadow_cfg.escaped_delimiter_code = value[7:0];
            REG_ESCAPED_ESCAPE_CODE:    shadow_cfg.escaped_escape_code    = value[7:0];
            REG_FRAME_LENGTH:           shadow_cfg.frame_length           = value[8:0];
            default: ;
        endcase
    endtask

    // Holds the sender until every due result has come out, then lets trailing requests
    // that cause no result drain from the block's queue.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (decodes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sends one raw byte request. A typed expectation, where given, replaces the computed one,
    // while the shadow state still follows the byte.
    task automatic send_raw(input logic [7:0] raw, input logic last, input bit typed,
                            input bit typed_has, input decode_result_t typed_result);
        decode_result_t res;
        bit             has;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        raw_byte   <= raw;
        final_byte <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        has = unstuff_byte(raw, last, res);
        if (typed)
        begin
            has = typed_has;
            res = typed_result;
        end
        if (has)
        begin
            decodes_due.push_back(res);
        end
    endtask

    // Builds one frame of raw bytes and sends it. Half of the frames are well formed with random
    // content, so that full lengths and clean checksums are reached; the rest are broken.
    task automatic send_frame();
        logic [7:0]   data_q [$];
        logic [7:0]   raw_q [$];
        frame_shape_t shape;
        int           limit;
        int           n;
        int           spot;
        int           pick;
        logic [7:0]   sum;
        logic [7:0]   d;
        logic [7:0]   follower;
        bit           last;
        limit = frame_limit();
        pick  = $urandom_range(0, 9);
        shape = (pick <= 4) ? SHAPE_GOOD :
                (pick == 5) ? SHAPE_BAD_SUM :
                (pick == 6) ? SHAPE_ODD_LENGTH :
                (pick == 7) ? SHAPE_BAD_ESCAPE : SHAPE_NOISE;
        if (shape == SHAPE_NOISE)
        begin
            // Raw noise leaning on the three codes, with stray frame ends inside.
            n = $urandom_range(1, limit + 3);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 5))
                    0: d = shadow_cfg.escape_code;
                    1: d = shadow_cfg.escaped_delimiter_code;
                    2: d = shadow_cfg.escaped_escape_code;
                    default: d = 8'($urandom());
                endcase
                last = (i == n - 1) || ($urandom_range(0, 7) == 0);
                send_raw(d, last, 1'b0, 1'b0, NO_RESULT);
            end
        end
        else
        begin
            n   = (shape == SHAPE_ODD_LENGTH) ? $urandom_range(1, limit + 2) :
                  (shape == SHAPE_BAD_ESCAPE) ? $urandom_range(1, limit) : limit;
            sum = 8'h00;
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 5))
                    0: d = shadow_cfg.escape_code;
                    1: d = shadow_cfg.delimiter_value;
                    default: d = 8'($urandom());
                endcase
                // The closing byte of a good frame is the checksum that zeroes the XOR.
                if (i == n - 1 && shape == SHAPE_GOOD)
                begin
                    d = sum;
                end
                sum = sum ^ d;
                data_q.push_back(d);
            end
            foreach (data_q[i])
            begin
                if (data_q[i] == shadow_cfg.escape_code)
                begin
                    raw_q.push_back(shadow_cfg.escape_code);
                    raw_q.push_back(shadow_cfg.escaped_escape_code);
                end
                else if (data_q[i] == shadow_cfg.delimiter_value && $urandom_range(0, 1))
                begin
                    raw_q.push_back(shadow_cfg.escape_code);
                    raw_q.push_back(shadow_cfg.escaped_delimiter_code);
                end
                else
                begin
                    raw_q.push_back(data_q[i]);
                end
            end
            if (shape == SHAPE_BAD_ESCAPE)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    // Escape as the very last raw byte of the frame.
                    raw_q.push_back(shadow_cfg.escape_code);
                end
                else
                begin
                    follower = 8'($urandom());
                    while (follower == shadow_cfg.escaped_delimiter_code ||
                           follower == shadow_cfg.escaped_escape_code)
                    begin
                        follower = 8'($urandom());
                    end
                    spot = $urandom_range(0, raw_q.size());
                    raw_q.insert(spot, follower);
                    raw_q.insert(spot, shadow_cfg.escape_code);
                end
            end
            foreach (raw_q[i])
            begin
                send_raw(raw_q[i], i == raw_q.size() - 1, 1'b0, 1'b0, NO_RESULT);
            end
        end
    endtask

    // Receiver: checks every result request taken at this edge against the oldest one due,
    // then picks the stall for the next cycle.
    always @(posedge clk)
    begin
        decode_result_t got;
        decode_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{byte_valid, decoded_byte, byte_position, frame_end,
                    frame_status_t'(frame_status)};
            if (decodes_due.size() == 0)
            begin
                report_mismatch("result with nothing due", NO_RESULT, got);
            end
            else
            begin
                want = decodes_due.pop_front();
                if (got.byte_valid !== want.byte_valid ||
                    got.decoded_byte !== want.decoded_byte ||
                    got.byte_position !== want.byte_position ||
                    got.frame_end !== want.frame_end ||
                    got.frame_status !== want.frame_status)
                begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: a run that never drains ends here as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [7:0] esc;
        logic [7:0] delim;
        logic [7:0] esc_delim;
        logic [7:0] esc_esc;
        logic [8:0] length;
        idle_mode_t mode;
        int         budget;
        int         start_count;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with no idling on either side.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_LENGTH)
            begin
                wait_for_results();
                write_register(REG_FRAME_LENGTH, 32'(directed_rows[i].new_length));
            end
            else
            begin
                send_raw(directed_rows[i].raw, directed_rows[i].last, directed_rows[i].typed,
                         directed_rows[i].typed_has, directed_rows[i].typed_result);
            end
        end

        // Random phases. Each one starts from an idle block, loads all five registers and
        // picks how the two sides idle; two phases load the extreme code and length values.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            esc       = 8'($urandom());
            delim     = 8'($urandom());
            esc_delim = 8'($urandom());
            esc_esc   = 8'($urandom());
            length    = 9'($urandom_range(1, 16));
            budget    = 190;
            case (phase)
                0:
                begin
                    esc       = RESET_ESCAPE_CODE;
                    delim     = RESET_DELIMITER_VALUE;
                    esc_delim = RESET_ESCAPED_DELIMITER_CODE;
                    esc_esc   = RESET_ESCAPED_ESCAPE_CODE;
                    length    = 9'($urandom_range(1, 12));
                end
                2:
                begin
                    // Length zero behaves as a one byte frame.
                    esc       = 8'h00;
                    delim     = 8'hFF;
                    esc_delim = 8'hFF;
                    esc_esc   = 8'h00;
                    length    = 9'd0;
                end
                3:
                begin
                    // Largest length value clamps to the maximum frame size.
                    esc       = 8'hFF;
                    delim     = 8'h00;
                    esc_delim = 8'h00;
                    esc_esc   = 8'hFF;
                    length    = 9'h1FF;
                    budget    = 260;
                end
                6:
                begin
                    // Both followers equal: the delimiter reading takes precedence.
                    esc_esc = esc_delim;
                end
                7:
                begin
                    length = 9'($urandom_range(2, 40));
                end
                default: ;
            endcase

            wait_for_results();
            write_register(REG_ESCAPE_CODE,            {24'($urandom()), esc});
            write_register(REG_DELIMITER_VALUE,        {24'($urandom()), delim});
            write_register(REG_ESCAPED_DELIMITER_CODE, {24'($urandom()), esc_delim});
            write_register(REG_ESCAPED_ESCAPE_CODE,    {24'($urandom()), esc_esc});
            write_register(REG_FRAME_LENGTH,           {23'($urandom()), length});

            mode = idle_mode_t'(phase % 4);
            send_idle_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 34 : 0;
            stall_pct     = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 34 : 0;

            start_count = items_sent;
            while (items_sent - start_count < budget)
            begin
                send_frame();
                // Now and then the sender holds off until the block has emptied.
                if ($urandom_range(0, 29) == 0)
                begin
                    wait_for_results();
                end
            end
        end

        wait_for_results();
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bufc_pkg.sv
rtl/bufc_cfg.sv
rtl/bufc_front.sv
rtl/bufc_queue.sv
rtl/bufc_back.sv
rtl/byte_unstuff_frame_checker_top.sv
sim/tb.sv
